// ----- sv/mhpt_pkg.sv -----
// Package for the max-heap priority tracker.
// Holds the sizing constants, the transaction structs and the control codes.
// No dependencies.
package mhpt_pkg;

  localparam int HEAP_DEPTH = 16;
  localparam int VALUE_BITS = 6;
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int IDX_W      = CNT_W;

  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [IDX_W-1:0]      idx_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOTFOUND = 2'd2
  } status_t;

  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic op;
    val_t value;
  } in_item_t;

  typedef struct packed {
    val_t       top_value;
    logic       is_empty;
    logic [4:0] entry_count;
    logic [1:0] status;
  } out_item_t;

  // Operation broadcast to every cell of the row.
  typedef enum logic [2:0] {
    MD_IDLE,
    MD_LOAD,
    MD_SCAN,
    MD_MOVE,
    MD_UP,
    MD_DOWN
  } mode_t;

  typedef struct packed {
    mode_t mode;
    idx_t  k;
    cnt_t  size;
    val_t  value;
    val_t  tail;
  } bcast_t;

  // Per-cell decisions for the current cycle.
  typedef struct packed {
    logic up_swap;
    logic dn_left;
    logic dn_right;
    logic hit;
  } cell_flags_t;

  // Row-wide OR of the cell decisions, seen by the sequencer.
  typedef struct packed {
    logic any_up;
    logic any_left;
    logic any_right;
    logic any_hit;
  } row_sum_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_MOVE,
    ST_DOWN,
    ST_UP,
    ST_DONE
  } state_t;

endpackage

// ----- sv/mhpt_cell.sv -----
// One heap slot: holds a value and swaps with its parent or children.
// Wired to its tree neighbours at fixed places. Depends on mhpt_pkg.
module mhpt_cell import mhpt_pkg::*; (
  input  logic        clk,
  input  idx_t        slot,
  input  bcast_t      bc,
  input  val_t        parent_val,
  input  val_t        left_val,
  input  val_t        right_val,
  input  logic        par_dn,
  input  logic        left_up,
  input  logic        right_up,
  output val_t        val,
  output val_t        tail,
  output cell_flags_t flags
);

  val_t            val_r;
  val_t            val_nxt;
  logic [IDX_W:0]  lslot;
  logic [IDX_W:0]  rslot;
  logic [IDX_W:0]  size_x;
  logic            me;
  logic            lok;
  logic            rok;
  val_t            best;

  assign lslot  = {slot, 1'b0};
  assign rslot  = {slot, 1'b1};
  assign size_x = {1'b0, bc.size};
  assign me     = (slot == bc.k);

  always_comb begin
    lok  = (lslot <= size_x) && (left_val > val_r);
    best = lok ? left_val : val_r;
    rok  = (rslot <= size_x) && (right_val > best);

    flags.up_swap  = (bc.mode == MD_UP) && me && (slot > idx_t'(1)) &&
                     (slot <= bc.size) && (val_r > parent_val);
    flags.dn_left  = (bc.mode == MD_DOWN) && me && (slot <= bc.size) && lok && !rok;
    flags.dn_right = (bc.mode == MD_DOWN) && me && (slot <= bc.size) && rok;
    flags.hit      = (bc.mode == MD_SCAN) && me && (val_r == bc.value);
  end

  always_comb begin
    val_nxt = val_r;
    unique case (bc.mode)
      MD_LOAD: if (me) val_nxt = bc.value;
      MD_MOVE: if (me) val_nxt = bc.tail;
      MD_UP: begin
        if (flags.up_swap)  val_nxt = parent_val;
        else if (left_up)   val_nxt = left_val;
        else if (right_up)  val_nxt = right_val;
      end
      MD_DOWN: begin
        if (flags.dn_left)       val_nxt = left_val;
        else if (flags.dn_right) val_nxt = right_val;
        else if (par_dn)         val_nxt = parent_val;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val  = val_r;
  assign tail = (slot == bc.size) ? val_r : '0;

endmodule

// ----- sv/mhpt_ctrl.sv -----
// Sequencer for the heap row: load, scan, move, sift down and sift up.
// Owns the entry count and the result register. Depends on mhpt_pkg.
module mhpt_ctrl import mhpt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  row_sum_t  sum,
  input  val_t      tail_val,
  input  val_t      root_val,
  output bcast_t    bc
);

  state_t    state_r, state_nxt;
  cnt_t      size_r, size_nxt;
  idx_t      k_r, k_nxt;
  idx_t      found_r, found_nxt;
  val_t      v_r, v_nxt;
  status_t   stat_r, stat_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;
  logic      out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    found_r <= found_nxt;
    v_r     <= v_nxt;
    stat_r  <= stat_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    k_nxt         = k_r;
    found_nxt     = found_r;
    v_nxt         = v_r;
    stat_nxt      = stat_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    bc.mode  = MD_IDLE;
    bc.k     = k_r;
    bc.size  = size_r;
    bc.value = v_r;
    bc.tail  = tail_val;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          v_nxt    = in_item.value;
          stat_nxt = STAT_OK;
          if (in_item.op == OP_PUSH) begin
            if (size_r >= cnt_t'(HEAP_DEPTH)) begin
              stat_nxt  = STAT_FULL;
              state_nxt = ST_DONE;
            end else begin
              size_nxt  = size_r + cnt_t'(1);
              k_nxt     = idx_t'(size_r + cnt_t'(1));
              state_nxt = ST_LOAD;
            end
          end else if (size_r == '0) begin
            stat_nxt  = STAT_NOTFOUND;
            state_nxt = ST_DONE;
          end else begin
            k_nxt     = idx_t'(1);
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_LOAD: begin
        bc.mode   = MD_LOAD;
        state_nxt = ST_UP;
      end
      ST_SCAN: begin
        bc.mode = MD_SCAN;
        if (sum.any_hit) begin
          found_nxt = k_r;
          if (k_r == idx_t'(size_r)) begin
            size_nxt  = size_r - cnt_t'(1);
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_MOVE;
          end
        end else if (k_r == idx_t'(size_r)) begin
          stat_nxt  = STAT_NOTFOUND;
          state_nxt = ST_DONE;
        end else begin
          k_nxt = k_r + idx_t'(1);
        end
      end
      ST_MOVE: begin
        bc.mode   = MD_MOVE;
        size_nxt  = size_r - cnt_t'(1);
        state_nxt = ST_DOWN;
      end
      ST_DOWN: begin
        bc.mode = MD_DOWN;
        if (sum.any_left) begin
          k_nxt = {k_r[IDX_W-2:0], 1'b0};
        end else if (sum.any_right) begin
          k_nxt = {k_r[IDX_W-2:0], 1'b1};
        end else begin
          k_nxt     = found_r;
          state_nxt = ST_UP;
        end
      end
      ST_UP: begin
        bc.mode = MD_UP;
        if (sum.any_up) begin
          k_nxt = k_r >> 1;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_nxt.top_value   = (size_r != '0) ? root_val : '0;
          out_nxt.is_empty    = (size_r == '0);
          out_nxt.entry_count = 5'(size_r);
          out_nxt.status      = stat_r;
          out_valid_nxt       = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ----- sv/max_heap_priority_tracker_top.sv -----
// Max-heap priority tracker: top level.
// Instantiates the sequencer and the row of heap cells. Depends on mhpt_pkg,
// mhpt_cell and mhpt_ctrl.
//
// Use:
//   Input channel in_valid/in_ready/in_item carries one transaction per
//   operation: op = push or remove, value = priority. Output channel
//   out_valid/out_ready/out_item returns exactly one result transaction per
//   input: top value (0 when empty), empty flag, entry count and status
//   (ok, push dropped because full, remove value not found).
//   The heap lives in a row of HEAP_DEPTH cells, one per slot, each wired to
//   its parent and two children. A sequencer broadcasts one step per cycle.
//   Steps per transaction, accept to result registered:
//     push          : load into the new last slot, then sift-up swaps
//     full push     : straight to the result, as is a remove on an empty heap
//     remove        : slot scan, tail move, down swaps, up swaps; a miss, or a
//                     hit in the last slot, ends after the slot scan
//   The worst case at depth 16 is a hit in slot 15 of 16 with three swaps up;
//   the slot scan dominates it. One transaction is worked at a time;
//   in_ready is high only when idle. A finished result sits in the output
//   register, so the next transaction is accepted while the receiver stalls
//   and then waits to finish until the register is free.
//   Reset (rst_n low, synchronous) empties the heap and drops a pending result;
//   cells need no clearing as only slots up to the count are ever read.
module max_heap_priority_tracker_top import mhpt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  bcast_t      bc;
  val_t        val_a   [1:HEAP_DEPTH];
  val_t        tail_a  [1:HEAP_DEPTH];
  cell_flags_t flags_a [1:HEAP_DEPTH];
  row_sum_t    sum;
  val_t        tail_val;

  mhpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .sum       (sum),
    .tail_val  (tail_val),
    .root_val  (val_a[1]),
    .bc        (bc)
  );

  // Row of cells; the tree edges are fixed wiring.
  for (genvar j = 1; j <= HEAP_DEPTH; j++) begin : g_cell
    val_t pval, lval, rval;
    logic pdn, lup, rup;

    if (j == 1) begin : g_root
      assign pval = '0;
      assign pdn  = 1'b0;
    end else if (j % 2 == 0) begin : g_lchild
      assign pval = val_a[j/2];
      assign pdn  = flags_a[j/2].dn_left;
    end else begin : g_rchild
      assign pval = val_a[j/2];
      assign pdn  = flags_a[j/2].dn_right;
    end

    if (2*j <= HEAP_DEPTH) begin : g_haveleft
      assign lval = val_a[2*j];
      assign lup  = flags_a[2*j].up_swap;
    end else begin : g_noleft
      assign lval = '0;
      assign lup  = 1'b0;
    end

    if (2*j + 1 <= HEAP_DEPTH) begin : g_haveright
      assign rval = val_a[2*j+1];
      assign rup  = flags_a[2*j+1].up_swap;
    end else begin : g_noright
      assign rval = '0;
      assign rup  = 1'b0;
    end

    mhpt_cell u_cell (
      .clk        (clk),
      .slot       (idx_t'(j)),
      .bc         (bc),
      .parent_val (pval),
      .left_val   (lval),
      .right_val  (rval),
      .par_dn     (pdn),
      .left_up    (lup),
      .right_up   (rup),
      .val        (val_a[j]),
      .tail       (tail_a[j]),
      .flags      (flags_a[j])
    );
  end

  // Only the addressed cell raises a flag, so a plain OR gathers the row.
  always_comb begin
    sum      = '0;
    tail_val = '0;
    for (int j = 1; j <= HEAP_DEPTH; j++) begin
      sum.any_up    = sum.any_up    | flags_a[j].up_swap;
      sum.any_left  = sum.any_left  | flags_a[j].dn_left;
      sum.any_right = sum.any_right | flags_a[j].dn_right;
      sum.any_hit   = sum.any_hit   | flags_a[j].hit;
      tail_val      = tail_val      | tail_a[j];
    end
  end

endmodule

// ----- test/heap_report_checker.sv -----
// Checker for the max-heap priority tracker: watches both channels, predicts each report.
// Compares every report with the prediction. Depends on mhpt_pkg.
`timescale 1ns / 1ps
module heap_report_checker import mhpt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  in_item_t           in_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  out_item_t          out_item,
  output int unsigned        mismatch_count,
  output int unsigned        reports_waiting,
  output int unsigned        reports_checked,
  output int unsigned        overflow_seen,
  output int unsigned        notfound_seen,
  output int unsigned        empty_seen
);

  // Shadow heap, 1-indexed like the block.
  val_t        heap_slots [1:HEAP_DEPTH];
  int unsigned heap_count;
  out_item_t   expected_reports [$];

  function automatic void swap_slots(int unsigned a, int unsigned b);
    val_t t;
    t             = heap_slots[a];
    heap_slots[a] = heap_slots[b];
    heap_slots[b] = t;
  endfunction

  function automatic void bubble_up(int unsigned k);
    while (k > 1 && k <= heap_count && heap_slots[k] > heap_slots[k / 2]) begin
      swap_slots(k, k / 2);
      k = k / 2;
    end
  endfunction

  function automatic void bubble_down(int unsigned k);
    int unsigned l;
    int unsigned r;
    int unsigned best;
    while (k >= 1 && k <= heap_count) begin
      l    = 2 * k;
      r    = l + 1;
      best = k;
      if (l <= heap_count && heap_slots[l] > heap_slots[best]) best = l;
      if (r <= heap_count && heap_slots[r] > heap_slots[best]) best = r;
      if (best == k) break;
      swap_slots(k, best);
      k = best;
    end
  endfunction

  // Applies one operation to the shadow heap and returns the report it yields.
  function automatic out_item_t apply_heap_op(in_item_t t);
    status_t     st;
    int unsigned hit_slot;
    int unsigned i;
    out_item_t   r;
    st       = STAT_OK;
    hit_slot = 0;
    if (t.op == OP_PUSH) begin
      if (heap_count >= HEAP_DEPTH) begin
        st = STAT_FULL;
      end else begin
        heap_count++;
        heap_slots[heap_count] = t.value;
        bubble_up(heap_count);
      end
    end else begin
      for (i = 1; i <= heap_count; i++) begin
        if (hit_slot == 0 && heap_slots[i] == t.value) hit_slot = i;
      end
      if (hit_slot == 0) begin
        st = STAT_NOTFOUND;
      end else if (hit_slot != heap_count) begin
        heap_slots[hit_slot] = heap_slots[heap_count];
        heap_count--;
        bubble_down(hit_slot);
        bubble_up(hit_slot);
      end else begin
        heap_count--;
      end
    end
    r.top_value   = (heap_count > 0) ? heap_slots[1] : '0;
    r.is_empty    = (heap_count == 0);
    r.entry_count = 5'(heap_count);
    r.status      = st;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (heap_slots[i]) heap_slots[i] = '0;
      heap_count = 0;
      expected_reports.delete();
      mismatch_count  <= 0;
      reports_waiting <= 0;
      reports_checked <= 0;
      overflow_seen   <= 0;
      notfound_seen   <= 0;
      empty_seen      <= 0;
    end else begin
      // Result side first: a report leaving now belongs to an older transaction.
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          if (mismatch_count < 10)
            $display("checker: unexpected report top=%0d empty=%0d count=%0d status=%0d",
                     out_item.top_value, out_item.is_empty, out_item.entry_count,
                     out_item.status);
          mismatch_count <= mismatch_count + 1;
        end else begin
          automatic out_item_t want = expected_reports.pop_front();
          if (out_item.top_value   !== want.top_value   ||
              out_item.is_empty    !== want.is_empty    ||
              out_item.entry_count !== want.entry_count ||
              out_item.status      !== want.status) begin
            if (mismatch_count < 10)
              $display({"checker: mismatch at report %0d: expected top=%0d empty=%0d ",
                        "count=%0d status=%0d, got top=%0d empty=%0d count=%0d status=%0d"},
                       reports_checked, want.top_value, want.is_empty,
                       want.entry_count, want.status, out_item.top_value,
                       out_item.is_empty, out_item.entry_count, out_item.status);
            mismatch_count <= mismatch_count + 1;
          end
          if (want.status == STAT_FULL)     overflow_seen <= overflow_seen + 1;
          if (want.status == STAT_NOTFOUND) notfound_seen <= notfound_seen + 1;
          if (want.is_empty)                empty_seen    <= empty_seen + 1;
        end
        reports_checked <= reports_checked + 1;
      end
      if (in_valid && in_ready)
        expected_reports.push_back(apply_heap_op(in_item));
      reports_waiting <= expected_reports.size();
    end
  end

endmodule

// ----- test/testbench.sv -----
// Top level of the max-heap priority tracker testbench: clock, reset, stimulus, verdict.
// Depends on mhpt_pkg, max_heap_priority_tracker_top and heap_report_checker.
`timescale 1ns / 1ps
module testbench;
  import mhpt_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1800;
  // The slowest legal run is roughly 1830 items, each with its busy time, a stall
  // and a gap; the limit leaves a wide margin on top of that.
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  // Longer than the worst-case remove, so this covers any straggler.
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef enum int {
    PH_FILL,    // mostly pushes: drives the heap to full and into overflow
    PH_DRAIN,   // mostly removes: empties the heap, exercises not-found
    PH_MIXED,   // even split
    PH_DUPES    // narrow value range so duplicates pile up
  } phase_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      in_ready;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int unsigned mismatch_count;
  int unsigned reports_waiting;
  int unsigned reports_checked;
  int unsigned overflow_seen;
  int unsigned notfound_seen;
  int unsigned empty_seen;

  // Set during some phases: both sides run flat out with no idling at all.
  bit          steady_flow = 1'b0;
  // Stimulus-side view of what is in the heap, used only to choose removes
  // that hit; a push into a full heap is not added to it.
  val_t        live_values [$];
  int unsigned pushes_sent;
  int unsigned removes_sent;

  max_heap_priority_tracker_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  heap_report_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item        (out_item),
    .mismatch_count  (mismatch_count),
    .reports_waiting (reports_waiting),
    .reports_checked (reports_checked),
    .overflow_seen   (overflow_seen),
    .notfound_seen   (notfound_seen),
    .empty_seen      (empty_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned idle_cycles();
    int unsigned roll;
    if (steady_flow) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: ready in random runs broken by stalls of random length.
  initial begin : result_sink
    int unsigned n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      if (steady_flow) begin
        @(posedge clk);
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) @(posedge clk);
        n = idle_cycles();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  // Keeps the stimulus view of the heap in step with an accepted transaction.
  function automatic void track_live(logic op, val_t v);
    int unsigned i;
    if (op == OP_PUSH) begin
      if (live_values.size() < HEAP_DEPTH) live_values.push_back(v);
    end else begin
      for (i = 0; i < live_values.size(); i++) begin
        if (live_values[i] == v) begin
          live_values.delete(i);
          break;
        end
      end
    end
  endfunction

  // Offers one transaction and holds it until it is taken. Valid is left high
  // when no gap follows, so the next call simply changes the payload.
  task automatic send_op(logic op, val_t v);
    int unsigned gap;
    in_item  <= in_item_t'{op: op, value: v};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_live(op, v);
    if (op == OP_PUSH) pushes_sent++;
    else               removes_sent++;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender stands back until every outstanding report has been checked.
  task automatic wait_for_reports();
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_waiting != 0);
  endtask

  // Corners first: remove on an empty heap, both value extremes, duplicates,
  // an absent value, filling to the brim, a push into a full heap, and
  // removal of a duplicated value (the lowest slot must go).
  task automatic run_directed();
    val_t fill_vals [14];
    fill_vals = '{6'd42, 6'd21, 6'd63, 6'd7, 6'd56, 6'd0, 6'd35,
                  6'd14, 6'd49, 6'd28, 6'd62, 6'd1, 6'd33, 6'd10};
    send_op(OP_REMOVE, 6'd5);
    send_op(OP_PUSH,   6'd63);
    send_op(OP_PUSH,   6'd0);
    send_op(OP_PUSH,   6'd63);
    send_op(OP_REMOVE, 6'd63);
    send_op(OP_REMOVE, 6'd17);
    foreach (fill_vals[i]) send_op(OP_PUSH, fill_vals[i]);
    send_op(OP_PUSH,   6'd44);
    send_op(OP_REMOVE, 6'd0);
    send_op(OP_REMOVE, 6'd63);
  endtask

  task automatic run_random();
    phase_t      phase;
    int unsigned sent;
    int unsigned phase_left;
    int unsigned push_pct;
    bit          is_push;
    bit          first_boundary;
    val_t        v;
    sent           = 0;
    phase_left     = 0;
    first_boundary = 1'b1;
    phase          = PH_MIXED;
    push_pct       = 50;
    while (sent < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        // Phase boundary: the first one always pauses for the results to
        // drain, later ones only sometimes.
        if (first_boundary || $urandom_range(0, 3) == 0) wait_for_reports();
        first_boundary = 1'b0;
        phase       = phase_t'($urandom_range(0, 3));
        phase_left  = $urandom_range(40, 150);
        steady_flow = ($urandom_range(0, 4) == 0);
        case (phase)
          PH_FILL:  push_pct = 75;
          PH_DRAIN: push_pct = 25;
          PH_DUPES: push_pct = 55;
          default:  push_pct = 50;
        endcase
      end
      is_push = ($urandom_range(0, 99) < push_pct);
      if (is_push) begin
        v = (phase == PH_DUPES) ? val_t'($urandom_range(0, 3)) : val_t'($urandom_range(0, 63));
        send_op(OP_PUSH, v);
      end else begin
        // Most removes name a stored value; the rest are likely misses.
        if (live_values.size() > 0 && $urandom_range(0, 99) < 85)
          v = live_values[$urandom_range(0, live_values.size() - 1)];
        else
          v = val_t'($urandom_range(0, 63));
        send_op(OP_REMOVE, v);
      end
      sent++;
      phase_left--;
    end
  endtask

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench: timed out after %0d cycles", cycles);
    $display("testbench: done, errors");
    $finish;
  end

  initial begin : stimulus
    pushes_sent  = 0;
    removes_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    wait_for_reports();
    run_random();

    // Drain: everything outstanding must arrive, then a quiet settle period.
    steady_flow = 1'b0;
    wait_for_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("testbench: %0d transactions sent (%0d push, %0d remove), %0d reports checked",
             pushes_sent + removes_sent, pushes_sent, removes_sent, reports_checked);
    $display("testbench: %0d overflow, %0d not found, %0d empty reports, %0d mismatches",
             overflow_seen, notfound_seen, empty_seen, mismatch_count);
    if (mismatch_count == 0 && reports_waiting == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/mhpt_pkg.sv
sv/mhpt_cell.sv
sv/mhpt_ctrl.sv
sv/max_heap_priority_tracker_top.sv
test/heap_report_checker.sv
test/testbench.sv
